FILE: rtl/premultiplied_rgb565_hex_thumbnail_defines.svh
// assertion macros for the premultiplied rgb565 hex thumbnail encoder
`ifndef PREMULTIPLIED_RGB565_HEX_THUMBNAIL_DEFINES_SVH
`define PREMULTIPLIED_RGB565_HEX_THUMBNAIL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PMHEX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PMHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pmhex_pkg.sv
// shared types, constants and helpers of the hex thumbnail encoder
package pmhex_pkg;

	// frame geometry
	localparam int MAX_DIM = 1024;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int CFG_W   = 11;
	localparam int LIM_W   = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;

	// configuration register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_ROW_PIXELS = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_ROWS = IDX_W'(1);

	// pixel queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// output characters
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// codes that print as all zeros
	localparam logic [15:0] CODE_Z0 = 16'h0020;
	localparam logic [15:0] CODE_Z1 = 16'h0841;
	localparam logic [15:0] CODE_Z2 = 16'h0861;

	// one classified pixel
	typedef struct packed {
		logic [15:0] code;
		logic        semi;
		logic        row_end;
		logic        frame_end;
	} desc_t;

	// zero acts as one, oversize acts as MAX_DIM
	function automatic logic [LIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [LIM_W-1:0] w;
		w = LIM_W'(v);
		if (w == '0) begin
			return LIM_W'(1);
		end else if (w > LIM_W'(MAX_DIM)) begin
			return LIM_W'(MAX_DIM);
		end
		return w;
	endfunction

	// x*a rounded by (p + (p>>8) + 0x80) >> 8
	function automatic logic [7:0] premul(input logic [7:0] x, input logic [7:0] a);
		logic [15:0] p;
		logic [16:0] s;
		p = x * a;
		s = 17'(p) + 17'(p[15:8]) + 17'h80;
		return s[15:8];
	endfunction

	// lower-case hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + 8'(nib);
		end
		return CH_LOWER_A + 8'(nib - 4'd10);
	endfunction

endpackage

FILE: rtl/pmhex_front.sv
// front end: config registers, pixel premultiply and row/frame classification
module pmhex_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     alpha,
	input  logic                           cfg_we,
	input  logic [pmhex_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pmhex_pkg::CFG_W-1:0]    cfg_data,
	output pmhex_pkg::desc_t               desc
);

	logic [pmhex_pkg::CFG_W-1:0] row_pixels_q;
	logic [pmhex_pkg::CFG_W-1:0] frame_rows_q;
	logic [pmhex_pkg::CNT_W-1:0] column_q;
	logic [pmhex_pkg::CNT_W-1:0] row_q;
	logic [7:0]                  pr;
	logic [7:0]                  pg;
	logic [7:0]                  pb;
	logic [15:0]                 code_raw;
	logic                        row_end;
	logic                        frame_end;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= pmhex_pkg::CFG_W'(1);
			frame_rows_q <= pmhex_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				pmhex_pkg::REG_ROW_PIXELS: row_pixels_q <= cfg_data;
				pmhex_pkg::REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// premultiply and pack to rgb565
	always_comb begin
		pr       = pmhex_pkg::premul(red, alpha);
		pg       = pmhex_pkg::premul(green, alpha);
		pb       = pmhex_pkg::premul(blue, alpha);
		code_raw = {pr[7:3], pg[7:2], pb[7:3]};
	end

	// position in the frame
	assign row_end = (pmhex_pkg::LIM_W'(column_q) + pmhex_pkg::LIM_W'(1))
		>= pmhex_pkg::clamp_dim(row_pixels_q);
	assign frame_end = row_end && ((pmhex_pkg::LIM_W'(row_q) + pmhex_pkg::LIM_W'(1))
		>= pmhex_pkg::clamp_dim(frame_rows_q));

	// descriptor for the queue
	always_comb begin
		desc.code = (code_raw == pmhex_pkg::CODE_Z0 || code_raw == pmhex_pkg::CODE_Z1 ||
			code_raw == pmhex_pkg::CODE_Z2) ? 16'h0000 : code_raw;
		desc.semi      = (column_q == '0);
		desc.row_end   = row_end;
		desc.frame_end = frame_end;
	end

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				column_q <= '0;
				row_q    <= frame_end ? '0 : row_q + pmhex_pkg::CNT_W'(1);
			end else begin
				column_q <= column_q + pmhex_pkg::CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/pmhex_queue.sv
// short descriptor queue between front and back
module pmhex_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  pmhex_pkg::desc_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output pmhex_pkg::desc_t rd_data,
	output logic             empty
);

	pmhex_pkg::desc_t              slot_q [pmhex_pkg::QDEPTH];
	logic [pmhex_pkg::QPTR_W-1:0]  head_q;
	logic [pmhex_pkg::QPTR_W-1:0]  tail_q;
	logic [pmhex_pkg::QCNT_W-1:0]  count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full  = (count_q == pmhex_pkg::QCNT_W'(pmhex_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign rd_data = slot_q[head_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[tail_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				tail_q <= (tail_q == pmhex_pkg::QPTR_W'(pmhex_pkg::QDEPTH - 1)) ?
					'0 : tail_q + pmhex_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				head_q <= (head_q == pmhex_pkg::QPTR_W'(pmhex_pkg::QDEPTH - 1)) ?
					'0 : head_q + pmhex_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + pmhex_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - pmhex_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/pmhex_back.sv
// back end: byte sequencer and registered output stage
module pmhex_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pmhex_pkg::desc_t head,
	input  logic             head_valid,
	output logic             head_done,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_char,
	output logic             pixel_last,
	output logic             frame_done
);

	localparam logic [2:0] ST_SEMI = 3'd0;
	localparam logic [2:0] ST_HEX3 = 3'd1;
	localparam logic [2:0] ST_HEX2 = 3'd2;
	localparam logic [2:0] ST_HEX1 = 3'd3;
	localparam logic [2:0] ST_HEX0 = 3'd4;
	localparam logic [2:0] ST_NL   = 3'd5;

	logic [2:0] step_q;
	logic [2:0] step;
	logic       out_valid_q;
	logic       load;
	logic [7:0] ch;
	logic       last;
	logic       done;

	// skip the separator when the pixel does not open a row
	assign step = (step_q == ST_SEMI && !head.semi) ? ST_HEX3 : step_q;

	// output register is free when empty or being taken
	assign load      = head_valid && (!out_valid_q || pop);
	assign head_done = load && last;
	assign empty     = !out_valid_q;

	// byte for the current step
	always_comb begin
		ch   = pmhex_pkg::CH_SEMI;
		last = 1'b0;
		done = 1'b0;
		case (step)
			ST_SEMI: ch = pmhex_pkg::CH_SEMI;
			ST_HEX3: ch = pmhex_pkg::hex_char(head.code[15:12]);
			ST_HEX2: ch = pmhex_pkg::hex_char(head.code[11:8]);
			ST_HEX1: ch = pmhex_pkg::hex_char(head.code[7:4]);
			ST_HEX0: begin
				ch   = pmhex_pkg::hex_char(head.code[3:0]);
				last = !head.row_end;
			end
			ST_NL: begin
				ch   = pmhex_pkg::CH_NEWLINE;
				last = 1'b1;
				done = head.frame_end;
			end
			default: ch = pmhex_pkg::CH_SEMI;
		endcase
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_SEMI;
		end else if (load) begin
			step_q <= last ? ST_SEMI : step + 3'd1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char   <= ch;
			pixel_last <= last;
			frame_done <= done;
		end
	end

endmodule

FILE: rtl/premultiplied_rgb565_hex_thumbnail.sv
// top level of the premultiplied rgb565 hex thumbnail encoder
// Takes one RGBA pixel per transfer, premultiplies it by alpha, packs it to
// RGB565 and emits the code as lower-case hex text, one byte per transfer on
// the result side: ';' opens each row, four hex digits follow per pixel and a
// newline closes each row, so a pixel takes four to six bytes at the output.
// The byte sequencer in the back end emits one byte per cycle while pop is high; the
// front end classifies a pixel in the cycle it is accepted, and the descriptor
// queue holds up to four pixels, the one being emitted included, so the input
// runs up to three pixels ahead of the output before it stalls. Sizes come
// from row_pixels (index 0) and frame_rows (index 1); zero acts as one and
// values above 1024 act as 1024. cfg_ready is always high.
`include "premultiplied_rgb565_hex_thumbnail_defines.svh"

module premultiplied_rgb565_hex_thumbnail (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic [7:0]                     alpha,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_char,
	output logic                           pixel_last,
	output logic                           frame_done,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmhex_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pmhex_pkg::CFG_W-1:0]    cfg_data
);

	pmhex_pkg::desc_t desc;
	pmhex_pkg::desc_t head;
	logic             q_full;
	logic             q_empty;
	logic             head_done;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	// front end
	pmhex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.desc      (desc)
	);

	// descriptor queue
	pmhex_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (desc),
		.full    (q_full),
		.rd_en   (head_done),
		.rd_data (head),
		.empty   (q_empty)
	);

	// back end
	pmhex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.head_done  (head_done),
		.pop        (pop),
		.empty      (empty),
		.out_char   (out_char),
		.pixel_last (pixel_last),
		.frame_done (frame_done)
	);

	// frame end only on the closing newline
	`PMHEX_ASSERT_NOW(a_frame_done_nl, !empty && frame_done, pixel_last && out_char == pmhex_pkg::CH_NEWLINE, "frame_done off a newline")

	// row separator never ends a pixel
	`PMHEX_ASSERT_NOW(a_semi_not_last, !empty && out_char == pmhex_pkg::CH_SEMI, !pixel_last && !frame_done, "separator flagged as last")

	// a pixel in progress keeps the output fed
	`PMHEX_ASSERT_NEXT(a_pixel_continues, !empty && !pixel_last, !empty, "output ran dry inside a pixel")

endmodule

FILE: verif/tb.sv
// testbench of the premultiplied rgb565 hex thumbnail encoder: directed and random pixels
module tb;

	localparam int CLK_PERIOD = 12;

	// register indexes the block does not decode
	localparam logic [pmhex_pkg::IDX_W-1:0] REG_SPARE_2 = pmhex_pkg::IDX_W'(2);
	localparam logic [pmhex_pkg::IDX_W-1:0] REG_SPARE_3 = pmhex_pkg::IDX_W'(3);

	localparam string HEX_DIGITS = "0123456789abcdef";

	// one emitted text byte with its flags
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       done;
	} text_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic [7:0] alpha = '0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] out_char;
	logic pixel_last;
	logic frame_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pmhex_pkg::IDX_W-1:0] cfg_index = '0;
	logic [pmhex_pkg::CFG_W-1:0] cfg_data = '0;

	// predictor state
	logic [pmhex_pkg::CFG_W-1:0] row_pixels_cfg = pmhex_pkg::CFG_W'(1);
	logic [pmhex_pkg::CFG_W-1:0] frame_rows_cfg = pmhex_pkg::CFG_W'(1);
	int col_pos = 0;
	int row_pos = 0;
	text_byte_t pending_text[$];

	// traffic shaping
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	int fault_count = 0;
	int bytes_seen = 0;

	premultiplied_rgb565_hex_thumbnail u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.pixel_last (pixel_last),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// size register as the block uses it
	function automatic int effective_dim(input logic [pmhex_pkg::CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > pmhex_pkg::MAX_DIM) begin
			return pmhex_pkg::MAX_DIM;
		end
		return int'(v);
	endfunction

	// channel scaled by alpha with the rounding of the encoder
	function automatic logic [7:0] scale_by_alpha(input logic [7:0] x, input logic [7:0] a);
		int p;
		p = int'(x) * int'(a);
		return 8'((p + (p >> 8) + 128) >> 8);
	endfunction

	function automatic void add_byte(input logic [7:0] ch, input logic last, input logic done);
		text_byte_t t;
		t.ch = ch;
		t.last = last;
		t.done = done;
		pending_text.push_back(t);
	endfunction

	// text bytes one pixel produces, advancing the frame position
	function automatic void predict_text(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		logic [7:0] pr, pg, pb;
		logic [15:0] code;
		logic row_end, frame_end;
		pr = scale_by_alpha(r, a);
		pg = scale_by_alpha(g, a);
		pb = scale_by_alpha(b, a);
		code = {pr[7:3], pg[7:2], pb[7:3]};
		// near-black codes print as all zeros
		if (code == pmhex_pkg::CODE_Z0 || code == pmhex_pkg::CODE_Z1 ||
			code == pmhex_pkg::CODE_Z2) begin
			code = '0;
		end
		row_end = (col_pos + 1) >= effective_dim(row_pixels_cfg);
		frame_end = row_end && ((row_pos + 1) >= effective_dim(frame_rows_cfg));
		if (col_pos == 0) begin
			add_byte(pmhex_pkg::CH_SEMI, 1'b0, 1'b0);
		end
		for (int i = 3; i >= 0; i--) begin
			add_byte(HEX_DIGITS[code[i*4 +: 4]], !row_end && i == 0, 1'b0);
		end
		if (row_end) begin
			add_byte(pmhex_pkg::CH_NEWLINE, 1'b1, frame_end);
			col_pos = 0;
			row_pos = frame_end ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endfunction

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// result side: compare each transfer, then pick the next pop
	always @(posedge clk) begin
		text_byte_t want;
		if (arst_n && pop && !empty) begin
			if (pending_text.size() == 0) begin
				note_fault($sformatf("byte %0d: unexpected char %h last %b done %b",
					bytes_seen, out_char, pixel_last, frame_done));
			end else begin
				want = pending_text.pop_front();
				if (out_char !== want.ch || pixel_last !== want.last ||
					frame_done !== want.done) begin
					note_fault($sformatf(
						"byte %0d: expected char %h last %b done %b, got char %h last %b done %b",
						bytes_seen, want.ch, want.last, want.done,
						out_char, pixel_last, frame_done));
				end
			end
			bytes_seen++;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one pixel transfer; push stays high so back-to-back pixels need no gap
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		alpha <= a;
		do @(posedge clk); while (full);
		predict_text(r, g, b, a);
	endtask

	// stop sending and wait until every expected byte has arrived
	task automatic drain_text();
		push <= 1'b0;
		while (pending_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pmhex_pkg::IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= pmhex_pkg::CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pmhex_pkg::REG_ROW_PIXELS: begin
				row_pixels_cfg = pmhex_pkg::CFG_W'(value);
			end
			pmhex_pkg::REG_FRAME_ROWS: begin
				frame_rows_cfg = pmhex_pkg::CFG_W'(value);
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_geometry(input int cols, input int rows);
		drain_text();
		write_reg(pmhex_pkg::REG_ROW_PIXELS, cols);
		write_reg(pmhex_pkg::REG_FRAME_ROWS, rows);
	endtask

	// mostly random pixels, with alpha extremes and near-black codes mixed in
	task automatic send_random_pixel();
		logic [7:0] r, g, b, a;
		int kind;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		a = 8'($urandom);
		kind = $urandom_range(9);
		case (kind)
			0: a = 8'h00;
			1: a = 8'hff;
			2: begin
				a = 8'hff;
				case ($urandom_range(2))
					0: begin
						r = 8'($urandom_range(7));
						g = 8'(4 + $urandom_range(3));
						b = 8'($urandom_range(7));
					end
					1: begin
						r = 8'(8 + $urandom_range(7));
						g = 8'(8 + $urandom_range(3));
						b = 8'(8 + $urandom_range(7));
					end
					default: begin
						r = 8'(8 + $urandom_range(7));
						g = 8'(12 + $urandom_range(3));
						b = 8'(8 + $urandom_range(7));
					end
				endcase
			end
			default: begin
			end
		endcase
		send_pixel(r, g, b, a);
	endtask

	// reset sizes: every pixel is a whole row and a whole frame
	task automatic test_reset_sizes();
		send_pixel(8'h12, 8'h34, 8'h56, 8'hff);
		send_pixel(8'hab, 8'hcd, 8'hef, 8'h80);
	endtask

	// channel and alpha extremes over a 4x2 frame
	task automatic test_field_extremes();
		set_geometry(4, 2);
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'hff, 8'hff, 8'h00);
		send_pixel(8'hff, 8'h00, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'h00, 8'hff);
		send_pixel(8'h00, 8'h00, 8'hff, 8'hff);
		send_pixel(8'hff, 8'hff, 8'hff, 8'h01);
		send_pixel(8'hc8, 8'h64, 8'h32, 8'h80);
	endtask

	// the three near-black codes and one neighbor that prints as is
	task automatic test_zeroed_codes();
		send_pixel(8'h00, 8'h04, 8'h00, 8'hff);
		send_pixel(8'h08, 8'h08, 8'h08, 8'hff);
		send_pixel(8'h08, 8'h0c, 8'h08, 8'hff);
		send_pixel(8'h08, 8'h08, 8'h00, 8'hff);
	endtask

	// zero and oversize sizes, shrink mid-row, undecoded indexes
	task automatic test_size_registers();
		set_geometry(0, 1);
		send_pixel(8'h40, 8'h80, 8'hc0, 8'hff);
		send_pixel(8'h7f, 8'h7f, 8'h7f, 8'h7f);
		set_geometry(2047, 1024);
		send_pixel(8'h11, 8'h22, 8'h33, 8'hff);
		send_pixel(8'h44, 8'h55, 8'h66, 8'hff);
		send_pixel(8'h77, 8'h88, 8'h99, 8'hff);
		// column already past the new width: this pixel closes row and frame
		set_geometry(2, 0);
		send_pixel(8'hfe, 8'hdc, 8'hba, 8'hff);
		drain_text();
		write_reg(REG_SPARE_2, 0);
		write_reg(REG_SPARE_3, 2047);
		send_pixel(8'h01, 8'h02, 8'h03, 8'hff);
		set_geometry(1024, 1);
		send_pixel(8'h98, 8'h76, 8'h54, 8'hff);
	endtask

	// receiver holds off while pixels keep coming, so the input stalls
	task automatic test_output_hold();
		set_geometry(3, 2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 150;
		repeat (24) send_random_pixel();
	endtask

	task automatic run_traffic_phase(input int idle_pct, input int stall_pct, input int count);
		int cols, rows;
		cols = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 7);
		rows = $urandom_range(0, 4);
		set_geometry(cols, rows);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_pixel();
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(0, 0, 50);
		run_traffic_phase(68, 0, 50);
		run_traffic_phase(0, 68, 50);
		run_traffic_phase(29, 29, 50);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_field_extremes();
		test_zeroed_codes();
		test_size_registers();
		test_output_hold();
		test_random_traffic();
		drain_text();
		repeat (16) @(posedge clk);
		if (fault_count == 0 && pending_text.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#(CLK_PERIOD * 400000);
		$display("tb failed");
		$finish;
	end

endmodule
